// File: rtl/integer_stack_machine_unit_macros.svh
// Assertion macros for the stack machine unit
`ifndef INTEGER_STACK_MACHINE_UNIT_MACROS_SVH
`define INTEGER_STACK_MACHINE_UNIT_MACROS_SVH
// implication checked on every clock outside reset
`define ISM_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication checked on the next clock
`define ISM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/ism_pkg.sv
// Package for the stack machine unit: opcodes, statuses, kinds, state and command types
`default_nettype none
package ism_pkg;
  localparam logic [3:0] OP_PUSH = 4'd0, OP_PALL = 4'd1, OP_PINT = 4'd2, OP_POP = 4'd3,
    OP_NOP = 4'd4, OP_SWAP = 4'd5, OP_ADD = 4'd6, OP_SUB = 4'd7, OP_DIV = 4'd8,
    OP_MUL = 4'd9, OP_MOD = 4'd10, OP_PCHAR = 4'd11, OP_PSTR = 4'd12, OP_ROTL = 4'd13,
    OP_ROTR = 4'd14, OP_UNKNOWN = 4'd15;
  localparam logic [2:0] ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_SHORT = 3'd2, ST_DIVZ = 3'd3,
    ST_CHAR = 3'd4, ST_FULL = 3'd5, ST_UNKNOWN = 3'd6;
  localparam logic [1:0] K_DONE = 2'd0, K_INT = 2'd1, K_CHAR = 2'd2, K_NL = 2'd3;
  localparam logic [31:0] CHAR_MAX_CODE = 32'd127;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_WAIT, S_CAP, S_EXEC, S_DIV, S_MUL, S_WB, S_WALK, S_WALKW, S_WALKD,
    S_ROT, S_ROTW, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic       ld_in;      // capture request
    logic       rd_en;
    logic       rd_sel_ptr; // read at walk pointer instead of top/second
    logic       rd_second;
    logic       cap_b;      // capture read data as b (top)
    logic       cap_a;
    logic       div_start;
    logic       mul_go;
    logic       wr_push;
    logic       wr_res;     // write arithmetic result at count-2
    logic       wr_swap_a;  // write b at count-2
    logic       wr_swap_b;  // write a at count-1
    logic       wr_rot;     // write hold at walk pointer
    logic       cnt_dec;
    logic       ptr_init;
    logic       ptr_step;
    logic       hold_from_rd;
    logic       out_load;
    logic [1:0] out_kind;
    logic [2:0] out_status;
    logic       out_from_rd;
    logic       out_last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [3:0] op;
    logic       empty;
    logic       short_stk;
    logic       full;
    logic       b_zero;
    logic       a_char_bad;
    logic       rd_char_ok;
    logic       ptr_done;
    logic       div_done;
    logic       out_busy;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/ism_if.sv
// Valid/ready channel interfaces for requests and results
`default_nettype none
interface ism_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  req_type;
  logic signed [31:0] push_value;
  modport source (output valid, req_type, push_value, input ready);
  modport sink (input valid, req_type, push_value, output ready);
endinterface

interface ism_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  out_kind;
  logic signed [31:0] out_value;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, out_kind, out_value, status, last, input ready);
  modport sink (input valid, out_kind, out_value, status, last, output ready);
endinterface
`default_nettype wire

// File: rtl/integer_stack_machine_unit.sv
// Top level of the integer stack machine unit
// One instruction at a time on a stack of STACK_DEPTH 32-bit signed entries held in
// a single-read-port RAM. Div and mod run through the serial divider, one quotient
// bit per cycle. Print-all, print-string and rotations walk the stack one entry at a
// time through the single RAM read port; rotations begin with a priming read of the
// wrapping entry.
// Results leave through a registered output stage; a result not yet taken holds
// off the next instruction and stalls the walks.
`default_nettype none
`include "integer_stack_machine_unit_macros.svh"
module integer_stack_machine_unit #(
  parameter int STACK_DEPTH = 32
) (
  input wire logic    clk,
  input wire logic    rst,
  ism_req_if.sink     req,
  ism_rsp_if.source   rsp
);
  ism_pkg::cmd_t  cmd;
  ism_pkg::stat_t st;

  ism_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
    .st(st), .cmd(cmd)
  );

  ism_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .req_type(req.req_type), .push_value(req.push_value),
    .cmd(cmd), .st(st), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .out_kind(rsp.out_kind), .out_value(rsp.out_value), .status(rsp.status),
    .last(rsp.last)
  );

  `ISM_ASSERT_IMP(a_no_load_when_busy, clk, rst, cmd.out_load, !st.out_busy)
  `ISM_ASSERT_IMP(a_accept_needs_free_out, clk, rst, req.valid && req.ready, !st.out_busy)
  `ISM_ASSERT_NEXT(a_load_shows_valid, clk, rst, cmd.out_load, rsp.valid)
endmodule
`default_nettype wire

// File: rtl/ism_ram.sv
// Generic single-write, single-read RAM with registered read
`default_nettype none
module ism_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: rtl/ism_div.sv
// Serial signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none
module ism_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      quo,
  output logic [31:0]      rem
);
  logic [31:0] q, d, r;
  logic [5:0]  cnt;
  logic        busy, neg_q, neg_r;
  logic [32:0] trial;

  assign trial = {r[30:0], q[31]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= a[31] ? -a : a;
      d     <= b[31] ? -b : b;
      r     <= '0;
      neg_q <= a[31] ^ b[31];
      neg_r <= a[31];
    end else if (busy) begin
      // magnitudes as unsigned; -INT_MIN stays 2^31 which fits unsigned
      if (!trial[32]) begin
        r <= trial[31:0];
        q <= {q[30:0], 1'b1};
      end else begin
        r <= {r[30:0], q[31]};
        q <= {q[30:0], 1'b0};
      end
    end
  end

  assign quo = neg_q ? -q : q;
  assign rem = neg_r ? -r : r;
endmodule
`default_nettype wire

// File: rtl/ism_ctrl.sv
// Controller state machine sequencing each instruction
`default_nettype none
module ism_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ism_pkg::stat_t st,
  output ism_pkg::cmd_t      cmd
);
  ism_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ism_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_ready = 1'b0;
    case (state)
      ism_pkg::S_IDLE: begin
        req_ready = !st.out_busy;
        if (req_valid && !st.out_busy) begin
          cmd.ld_in = 1'b1;
          state_next = ism_pkg::S_RD;
        end
      end
      ism_pkg::S_RD: begin
        cmd.out_load = 1'b1;
        cmd.out_last = 1'b1;
        cmd.out_kind = ism_pkg::K_DONE;
        cmd.out_status = ism_pkg::ST_OK;
        state_next = ism_pkg::S_IDLE;
        case (st.op)
          ism_pkg::OP_PUSH: begin
            if (st.full) cmd.out_status = ism_pkg::ST_FULL;
            else cmd.wr_push = 1'b1;
          end
          ism_pkg::OP_NOP: ;
          ism_pkg::OP_POP, ism_pkg::OP_PINT, ism_pkg::OP_PCHAR: begin
            if (st.empty) cmd.out_status = ism_pkg::ST_EMPTY;
            else if (st.op == ism_pkg::OP_POP) cmd.cnt_dec = 1'b1;
            else begin
              cmd = '0;
              cmd.rd_en = 1'b1;
              state_next = ism_pkg::S_WAIT;
            end
          end
          ism_pkg::OP_SWAP, ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_DIV,
          ism_pkg::OP_MUL, ism_pkg::OP_MOD: begin
            if (st.short_stk) cmd.out_status = ism_pkg::ST_SHORT;
            else begin
              cmd = '0;
              cmd.rd_en = 1'b1;
              state_next = ism_pkg::S_WAIT;
            end
          end
          ism_pkg::OP_PALL, ism_pkg::OP_PSTR, ism_pkg::OP_ROTL, ism_pkg::OP_ROTR: begin
            if (st.op == ism_pkg::OP_PALL && st.empty) ;
            else if ((st.op == ism_pkg::OP_ROTL || st.op == ism_pkg::OP_ROTR)
                     && st.short_stk) ;
            else if (st.op == ism_pkg::OP_PSTR && st.empty) cmd.out_kind = ism_pkg::K_NL;
            else begin
              cmd = '0;
              cmd.ptr_init = 1'b1;
              state_next = (st.op == ism_pkg::OP_ROTL || st.op == ism_pkg::OP_ROTR)
                           ? ism_pkg::S_ROT : ism_pkg::S_WALK;
            end
          end
          default: cmd.out_status = ism_pkg::ST_UNKNOWN;
        endcase
      end
      ism_pkg::S_WAIT: begin
        // top read issued last cycle; two-operand ops issue the second
        cmd.cap_b = 1'b1;
        if (st.op == ism_pkg::OP_PINT) begin
          cmd.out_load = 1'b1; cmd.out_from_rd = 1'b1; cmd.out_last = 1'b1;
          cmd.out_kind = ism_pkg::K_INT;
          state_next = ism_pkg::S_IDLE;
        end else if (st.op == ism_pkg::OP_PCHAR) state_next = ism_pkg::S_OUT;
        else begin
          cmd.rd_en = 1'b1;
          cmd.rd_second = 1'b1;
          state_next = ism_pkg::S_CAP;
        end
      end
      ism_pkg::S_CAP: begin
        cmd.cap_a = 1'b1;
        state_next = ism_pkg::S_EXEC;
      end
      ism_pkg::S_EXEC: begin
        state_next = ism_pkg::S_WB;
        case (st.op)
          ism_pkg::OP_SWAP: begin
            cmd.wr_swap_a = 1'b1;
            state_next = ism_pkg::S_WB;
          end
          ism_pkg::OP_DIV, ism_pkg::OP_MOD: begin
            if (st.b_zero) begin
              cmd.out_load = 1'b1; cmd.out_last = 1'b1;
              cmd.out_status = ism_pkg::ST_DIVZ;
              state_next = ism_pkg::S_IDLE;
            end else begin
              cmd.div_start = 1'b1;
              state_next = ism_pkg::S_DIV;
            end
          end
          ism_pkg::OP_MUL: begin
            cmd.mul_go = 1'b1;
            state_next = ism_pkg::S_MUL;
          end
          default: cmd.mul_go = 1'b1;
        endcase
      end
      ism_pkg::S_DIV: begin
        if (st.div_done) begin
          cmd.mul_go = 1'b1;
          state_next = ism_pkg::S_MUL;
        end
      end
      ism_pkg::S_MUL: state_next = ism_pkg::S_WB;
      ism_pkg::S_WB: begin
        cmd.out_load = 1'b1; cmd.out_last = 1'b1;
        if (st.op == ism_pkg::OP_SWAP) cmd.wr_swap_b = 1'b1;
        else begin
          cmd.wr_res = 1'b1;
          cmd.cnt_dec = 1'b1;
        end
        state_next = ism_pkg::S_IDLE;
      end
      ism_pkg::S_OUT: begin
        // pchar: char then newline, or a char-range error status
        if (st.a_char_bad) begin
          cmd.out_load = 1'b1; cmd.out_last = 1'b1;
          cmd.out_status = ism_pkg::ST_CHAR;
          state_next = ism_pkg::S_IDLE;
        end else if (!st.out_busy) begin
          cmd.out_load = 1'b1; cmd.out_kind = ism_pkg::K_CHAR; cmd.out_from_rd = 1'b1;
          state_next = ism_pkg::S_WALKD;
        end
      end
      ism_pkg::S_WALK: begin
        if (!st.out_busy) begin
          cmd.rd_en = 1'b1; cmd.rd_sel_ptr = 1'b1;
          state_next = ism_pkg::S_WALKW;
        end
      end
      ism_pkg::S_WALKW: begin
        if (st.op == ism_pkg::OP_PALL) begin
          cmd.out_load = 1'b1; cmd.out_from_rd = 1'b1; cmd.out_kind = ism_pkg::K_INT;
          cmd.out_last = st.ptr_done;
          cmd.ptr_step = 1'b1;
          state_next = st.ptr_done ? ism_pkg::S_IDLE : ism_pkg::S_WALK;
        end else if (st.rd_char_ok) begin
          cmd.out_load = 1'b1; cmd.out_from_rd = 1'b1; cmd.out_kind = ism_pkg::K_CHAR;
          cmd.ptr_step = 1'b1;
          state_next = st.ptr_done ? ism_pkg::S_WALKD : ism_pkg::S_WALK;
        end else state_next = ism_pkg::S_WALKD;
      end
      ism_pkg::S_WALKD: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1; cmd.out_kind = ism_pkg::K_NL; cmd.out_last = 1'b1;
          state_next = ism_pkg::S_IDLE;
        end
      end
      ism_pkg::S_ROT: begin
        // ptr_init set ptr to the source end; read it, then shift one by one
        cmd.rd_en = 1'b1; cmd.rd_sel_ptr = 1'b1;
        state_next = ism_pkg::S_ROTW;
      end
      ism_pkg::S_ROTW: begin
        // data read at ptr arrives; write held value there (not after the priming read), hold the new one
        cmd.hold_from_rd = 1'b1;
        cmd.wr_rot = 1'b1;
        cmd.ptr_step = 1'b1;
        if (st.ptr_done) begin
          cmd.out_load = 1'b1; cmd.out_last = 1'b1;
          state_next = ism_pkg::S_IDLE;
        end else state_next = ism_pkg::S_ROT;
      end
      default: state_next = ism_pkg::S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/ism_dp.sv
// Datapath: stack RAM, count, operands, divider, multiplier and result register
`default_nettype none
module ism_dp #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [3:0]     req_type,
  input  wire logic [31:0]    push_value,
  input  wire ism_pkg::cmd_t  cmd,
  output ism_pkg::stat_t      st,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output logic [1:0]          out_kind,
  output logic [31:0]         out_value,
  output logic [2:0]          status,
  output logic                last
);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [3:0]    op;
  logic [31:0]   val, a, b, res, hold, rdata, wdata, quo, rem;
  logic [CW-1:0] count;
  logic [AW-1:0] ptr, raddr, waddr, top_addr, sec_addr;
  logic          we, div_done;
  logic          rot_first;

  assign top_addr = AW'(count - CW'(1));
  assign sec_addr = AW'(count - CW'(2));

  ism_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .a(a), .b(b),
    .done(div_done), .quo(quo), .rem(rem)
  );

  always_comb begin
    raddr = cmd.rd_sel_ptr ? ptr : (cmd.rd_second ? sec_addr : top_addr);
    we = 1'b1;
    waddr = ptr;
    wdata = hold;
    if (cmd.wr_push) begin
      waddr = AW'(count); wdata = val;
    end else if (cmd.wr_res) begin
      waddr = sec_addr; wdata = res;
    end else if (cmd.wr_swap_a) begin
      waddr = sec_addr; wdata = b;
    end else if (cmd.wr_swap_b) begin
      waddr = top_addr; wdata = a;
    end else if (!cmd.wr_rot || rot_first) we = 1'b0;
  end

  ism_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(cmd.rd_en), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) count <= '0;
    else if (cmd.wr_push) count <= count + CW'(1);
    else if (cmd.cnt_dec) count <= count - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      op <= req_type; val <= push_value;
    end
    if (cmd.cap_b) b <= rdata;
    if (cmd.cap_a) a <= rdata;
    if (cmd.mul_go) begin
      case (op)
        ism_pkg::OP_ADD: res <= a + b;
        ism_pkg::OP_SUB: res <= a - b;
        ism_pkg::OP_MUL: res <= 32'(a * b);
        ism_pkg::OP_DIV: res <= quo;
        default:         res <= rem;
      endcase
    end
    // rotations prime hold with the wrapping entry (rotl the top, rotr the bottom), then
    // walk: rotl bottom to top, rotr top to bottom; print walks go top to bottom
    if (cmd.ptr_init) begin
      if (op == ism_pkg::OP_ROTR) ptr <= '0;
      else ptr <= top_addr;
    end else if (cmd.ptr_step) begin
      if (rot_first) ptr <= (op == ism_pkg::OP_ROTL) ? '0 : top_addr;
      else if (op == ism_pkg::OP_ROTL) ptr <= ptr + AW'(1);
      else ptr <= ptr - AW'(1);
    end
  end

  // priming read only loads hold; later steps write the held value and take the next
  always_ff @(posedge clk) begin
    if (cmd.ptr_init) rot_first <= (op == ism_pkg::OP_ROTL) || (op == ism_pkg::OP_ROTR);
    else if (cmd.hold_from_rd) rot_first <= 1'b0;
    if (cmd.hold_from_rd) hold <= rdata;
  end

  logic ptr_last;
  assign ptr_last = (op == ism_pkg::OP_ROTL) ? (ptr == top_addr) : (ptr == '0);

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (cmd.out_load) rsp_valid <= 1'b1;
    else if (rsp_ready) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind  <= cmd.out_kind;
      out_value <= cmd.out_from_rd ? (op == ism_pkg::OP_PCHAR ? b : rdata) : 32'd0;
      status    <= cmd.out_status;
      last      <= cmd.out_last;
    end
  end

  assign st.op         = op;
  assign st.empty      = (count == '0);
  assign st.short_stk  = (count < CW'(2));
  assign st.full       = (count >= CW'(STACK_DEPTH));
  assign st.b_zero     = (b == '0);
  assign st.a_char_bad = (b > ism_pkg::CHAR_MAX_CODE);
  assign st.rd_char_ok = (rdata != '0) && (rdata <= ism_pkg::CHAR_MAX_CODE);
  assign st.ptr_done   = rot_first ? 1'b0 : ptr_last;
  assign st.div_done   = div_done;
  assign st.out_busy   = rsp_valid && !rsp_ready;
endmodule
`default_nettype wire

// File: dv/integer_stack_machine_unit_checker.sv
// Result checker for the stack machine unit: models the stack and compares every result item
`default_nettype none
module integer_stack_machine_unit_checker #(
  parameter int STACK_DEPTH = 32
) (
  input wire logic clk,
  input wire logic rst,
  ism_req_if.sink  req,
  ism_rsp_if.sink  rsp,
  output int       errors,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic [2:0]  status;
    logic        last;
  } result_t;

  logic [31:0] model_stack [STACK_DEPTH];
  int          model_depth;
  result_t     expected_results [$];

  task automatic report(input string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic add_result(input logic [1:0] k, input logic [31:0] v, input logic [2:0] s);
    result_t r;
    r.kind = k;
    r.value = v;
    r.status = s;
    r.last = 1'b0;
    expected_results.push_back(r);
  endtask

  task automatic execute_instruction(input logic [3:0] op, input logic [31:0] operand);
    int c;
    logic [31:0] a, b, t;
    c = model_depth;
    case (op)
      ism_pkg::OP_PUSH: begin
        if (c >= STACK_DEPTH) add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_FULL);
        else begin
          model_stack[c] = operand;
          model_depth++;
          add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_OK);
        end
      end
      ism_pkg::OP_PALL: begin
        if (c == 0) add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_OK);
        for (int i = c - 1; i >= 0; i--)
          add_result(ism_pkg::K_INT, model_stack[i], ism_pkg::ST_OK);
      end
      ism_pkg::OP_PINT: begin
        if (c == 0) add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_EMPTY);
        else add_result(ism_pkg::K_INT, model_stack[c-1], ism_pkg::ST_OK);
      end
      ism_pkg::OP_POP: begin
        if (c == 0) add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_EMPTY);
        else begin
          model_depth--;
          add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_OK);
        end
      end
      ism_pkg::OP_NOP: add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_OK);
      ism_pkg::OP_SWAP, ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_DIV,
      ism_pkg::OP_MUL, ism_pkg::OP_MOD: begin
        if (c < 2) add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_SHORT);
        else begin
          a = model_stack[c-2];
          b = model_stack[c-1];
          if (op == ism_pkg::OP_SWAP) begin
            model_stack[c-2] = b;
            model_stack[c-1] = a;
            add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_OK);
          end else if ((op == ism_pkg::OP_DIV || op == ism_pkg::OP_MOD) && b == 0) begin
            add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_DIVZ);
          end else begin
            case (op)
              ism_pkg::OP_ADD: t = a + b;
              ism_pkg::OP_SUB: t = a - b;
              ism_pkg::OP_MUL: t = a * b;
              // 64-bit signed arithmetic keeps INT_MIN / -1 from overflowing
              ism_pkg::OP_DIV: t = 32'(longint'($signed(a)) / longint'($signed(b)));
              default: t = 32'(longint'($signed(a)) % longint'($signed(b)));
            endcase
            model_stack[c-2] = t;
            model_depth--;
            add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_OK);
          end
        end
      end
      ism_pkg::OP_PCHAR: begin
        if (c == 0) add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_EMPTY);
        else if (model_stack[c-1] > ism_pkg::CHAR_MAX_CODE)
          add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_CHAR);
        else begin
          add_result(ism_pkg::K_CHAR, model_stack[c-1], ism_pkg::ST_OK);
          add_result(ism_pkg::K_NL, 0, ism_pkg::ST_OK);
        end
      end
      ism_pkg::OP_PSTR: begin
        for (int i = c - 1; i >= 0; i--) begin
          if (model_stack[i] == 0 || model_stack[i] > ism_pkg::CHAR_MAX_CODE) break;
          add_result(ism_pkg::K_CHAR, model_stack[i], ism_pkg::ST_OK);
        end
        add_result(ism_pkg::K_NL, 0, ism_pkg::ST_OK);
      end
      ism_pkg::OP_ROTL: begin
        if (c >= 2) begin
          t = model_stack[c-1];
          for (int i = c - 1; i > 0; i--) model_stack[i] = model_stack[i-1];
          model_stack[0] = t;
        end
        add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_OK);
      end
      ism_pkg::OP_ROTR: begin
        if (c >= 2) begin
          t = model_stack[0];
          for (int i = 0; i < c - 1; i++) model_stack[i] = model_stack[i+1];
          model_stack[c-1] = t;
        end
        add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_OK);
      end
      default: add_result(ism_pkg::K_DONE, 0, ism_pkg::ST_UNKNOWN);
    endcase
    expected_results[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      model_depth = 0;
      expected_results.delete();
    end else begin
      // results first: an instruction cannot answer in the cycle it is taken
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) report("result item with none expected");
        else begin
          want = expected_results.pop_front();
          if (rsp.out_kind !== want.kind)
            report($sformatf("kind %0d, want %0d", rsp.out_kind, want.kind));
          if (rsp.out_value !== want.value)
            report($sformatf("value %0d, want %0d", rsp.out_value, $signed(want.value)));
          if (rsp.status !== want.status)
            report($sformatf("status %0d, want %0d", rsp.status, want.status));
          if (rsp.last !== want.last)
            report($sformatf("last %0b, want %0b", rsp.last, want.last));
        end
      end
      if (req.valid && req.ready) execute_instruction(req.req_type, req.push_value);
    end
    pending = expected_results.size();
  end
endmodule
`default_nettype wire

// File: dv/integer_stack_machine_unit_test.sv
// Testbench top for the stack machine unit: stimulus, stall phases and verdict
`default_nettype none
module integer_stack_machine_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 32;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   pending;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  ism_req_if req();
  ism_rsp_if rsp();

  integer_stack_machine_unit #(.STACK_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source)
  );

  integer_stack_machine_unit_checker #(.STACK_DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.sink), .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk)
    rsp.ready <= rst ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);

  // depth as the stimulus sees it, to steer pushes and pops
  int depth_seen = 0;

  // valid stays up after an accept; the next item or an idle cycle replaces it
  task automatic send_item(input logic [3:0] op, input logic [31:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.req_type <= op;
    req.push_value <= value;
    do @(posedge clk); while (!req.ready);
    case (op)
      ism_pkg::OP_PUSH: if (depth_seen < DEPTH) depth_seen++;
      ism_pkg::OP_POP: if (depth_seen > 0) depth_seen--;
      ism_pkg::OP_ADD, ism_pkg::OP_SUB, ism_pkg::OP_MUL: if (depth_seen >= 2) depth_seen--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return $urandom_range(1, 127);
      1: return $urandom_range(3) == 0 ? 32'd0 : 32'hFFFF_FFFF;
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: return $urandom_range(200) - 100;
      default: return $urandom();
    endcase
  endfunction

  task automatic drain();
    req.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic int u_checker_depth();
    return u_checker.model_depth;
  endfunction

  task automatic random_phase(input int count);
    int n;
    logic [3:0] op;
    for (int k = 0; k < count; k++) begin
      n = $urandom_range(99);
      if (n < 30 && depth_seen < DEPTH) op = ism_pkg::OP_PUSH;
      else if (n < 36) op = ism_pkg::OP_POP;
      else if (n < 40) op = 4'($urandom_range(15));
      else op = 4'($urandom_range(1, 14));
      // hold the stack short so pall and rotations stay quick
      if (op == ism_pkg::OP_PUSH && depth_seen > 8 && $urandom_range(3) != 0)
        op = ism_pkg::OP_POP;
      send_item(op, rand_value());
      if (op == ism_pkg::OP_DIV || op == ism_pkg::OP_MOD) depth_seen = -1;
      if (depth_seen < 0) begin
        // exact depth after div/mod is the checker's business; resync by draining
        drain();
        depth_seen = u_checker_depth();
      end
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.req_type = ism_pkg::OP_NOP;
    req.push_value = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: empty-stack errors, extremes, division corners, unknown opcode
    send_item(ism_pkg::OP_PALL, 0);
    send_item(ism_pkg::OP_PINT, 0);
    send_item(ism_pkg::OP_POP, 0);
    send_item(ism_pkg::OP_PCHAR, 0);
    send_item(ism_pkg::OP_PSTR, 0);
    send_item(ism_pkg::OP_ADD, 0);
    send_item(ism_pkg::OP_ROTL, 0);
    send_item(ism_pkg::OP_UNKNOWN, 32'hFFFF_FFFF);
    send_item(ism_pkg::OP_PUSH, 32'h8000_0000);
    send_item(ism_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_item(ism_pkg::OP_DIV, 0);
    send_item(ism_pkg::OP_PUSH, 32'hFFFF_FFFF);
    send_item(ism_pkg::OP_MOD, 0);
    send_item(ism_pkg::OP_PUSH, 0);
    send_item(ism_pkg::OP_DIV, 0);
    send_item(ism_pkg::OP_PCHAR, 0);
    send_item(ism_pkg::OP_PUSH, 32'd200);
    send_item(ism_pkg::OP_PCHAR, 0);
    send_item(ism_pkg::OP_PUSH, 32'd72);
    send_item(ism_pkg::OP_PUSH, 32'd105);
    send_item(ism_pkg::OP_PSTR, 0);
    send_item(ism_pkg::OP_ROTR, 0);
    send_item(ism_pkg::OP_SWAP, 0);
    send_item(ism_pkg::OP_PALL, 0);
    drain();
    depth_seen = u_checker_depth();
    // fill to overflow, print it all, rotate both ways, then empty again
    while (depth_seen < DEPTH) send_item(ism_pkg::OP_PUSH, 32'h7FFF_FFFF - depth_seen);
    send_item(ism_pkg::OP_PUSH, 1);
    send_item(ism_pkg::OP_PALL, 0);
    send_item(ism_pkg::OP_ROTL, 0);
    send_item(ism_pkg::OP_ROTR, 0);
    while (depth_seen > 0) send_item(ism_pkg::OP_POP, 0);

    random_phase(71);
    drain();
    send_idle_pct = 71;
    random_phase(71);
    send_idle_pct = 0;
    recv_stall_pct = 71;
    random_phase(71);
    send_idle_pct = 27;
    recv_stall_pct = 27;
    random_phase(71);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();

    if (errors == 0) $display("[integer_stack_machine_unit] OK");
    else $display("[integer_stack_machine_unit] ERROR");
    $finish;
  end

  initial begin
    #5ms;
    $display("[integer_stack_machine_unit] ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/ism_pkg.sv
rtl/ism_if.sv
rtl/ism_ram.sv
rtl/ism_div.sv
rtl/ism_ctrl.sv
rtl/ism_dp.sv
rtl/integer_stack_machine_unit.sv
dv/integer_stack_machine_unit_checker.sv
dv/integer_stack_machine_unit_test.sv
